FILE: rtl/core/mcpt_pkg.sv
// shared widths, item codes and divider handshake types for the periodic timer bank
package mcpt_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam int KIND_W    = 2;
  localparam int CHAN_W    = 3;
  localparam int PERIOD_W  = 24;
  localparam int ELAPSED_W = 20;
  localparam int COUNT_W   = 20;
  localparam int SUM_W     = PERIOD_W + 1;

  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSTALL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

  typedef struct packed {
    logic                start;
    logic [SUM_W-1:0]    dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_W-1:0]    quot;
    logic [PERIOD_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/core/mcpt_cmd_if.sv
// command channel: advance, install and remove items
interface mcpt_cmd_if;
  import mcpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [CHAN_W-1:0]    channel;
  logic [PERIOD_W-1:0]  period;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, kind, channel, period, elapsed, input ready);
  modport sink   (input valid, kind, channel, period, elapsed, output ready);
endinterface

FILE: rtl/core/mcpt_res_if.sv
// result channel: one fire count per active channel on an advance
interface mcpt_res_if;
  import mcpt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  fired_channel;
  logic [COUNT_W-1:0] fire_count;
  logic               last;

  modport source (output valid, fired_channel, fire_count, last, input ready);
  modport sink   (input valid, fired_channel, fire_count, last, output ready);
endinterface

FILE: rtl/core/multi_channel_periodic_timer.sv
// Install and remove items are taken while idle; the block is ready again in the next cycle.
// An advance scans one inactive channel per cycle; each active channel goes through the read
// and calc states, the 25-step divider when its period is nonzero, and the emit state, which
// waits while a result is stalled; an advance is handled one item at a time.
// Reset clears the active flags and control state; period and phase memories are
// not cleared and are written on install before they are read.
module multi_channel_periodic_timer #(
  parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS_DEF
) (
  input logic          clk,
  input logic          rst,
  mcpt_cmd_if.sink     cmd,
  mcpt_res_if.source   res
);
  import mcpt_pkg::*;

  localparam int IDX_W = $clog2(NUM_CHANNELS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]              state;
  logic [IDX_W-1:0]        idx;
  logic [NUM_CHANNELS-1:0] active;
  logic [ELAPSED_W-1:0]    el;
  logic [COUNT_W-1:0]      count;

  logic                    res_valid;
  logic [CHAN_W-1:0]       res_chan;
  logic [COUNT_W-1:0]      res_count;
  logic                    res_last;

  logic                    accept;
  logic                    ch_ok;
  logic [IDX_W-1:0]        cmd_addr;
  logic                    more;
  logic                    emit_go;

  logic                    period_we;
  logic                    phase_we;
  logic [IDX_W-1:0]        phase_waddr;
  logic [PERIOD_W-1:0]     phase_wdata;
  logic                    rd_en;
  logic [PERIOD_W-1:0]     period_rd;
  logic [PERIOD_W-1:0]     phase_rd;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign ch_ok     = 32'(cmd.channel) < NUM_CHANNELS;
  assign cmd_addr  = IDX_W'(cmd.channel);
  assign emit_go   = !res_valid || res.ready;

  // any active channel above the current one
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if (IDX_W'(j) > idx && active[j]) begin
        more = 1'b1;
      end
    end
  end

  assign period_we   = accept && cmd.kind == KIND_INSTALL && ch_ok;
  assign phase_we    = (period_we && !active[cmd_addr]) ||
                       (state == S_DIV && div_rsp.done);
  assign phase_waddr = (state == S_IDLE) ? cmd_addr : idx;
  assign phase_wdata = (state == S_IDLE) ? '0 : div_rsp.rem;
  assign rd_en       = (state == S_SCAN) && active[idx];

  mcpt_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_CHANNELS)) u_period_ram (
    .clk   (clk),
    .we    (period_we),
    .waddr (cmd_addr),
    .wdata (cmd.period),
    .re    (rd_en),
    .raddr (idx),
    .rdata (period_rd)
  );

  mcpt_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_CHANNELS)) u_phase_ram (
    .clk   (clk),
    .we    (phase_we),
    .waddr (phase_waddr),
    .wdata (phase_wdata),
    .re    (rd_en),
    .raddr (idx),
    .rdata (phase_rd)
  );

  assign div_req.start    = (state == S_CALC) && period_rd != '0;
  assign div_req.dividend = {1'b0, phase_rd} + SUM_W'(el);
  assign div_req.divisor  = period_rd;

  mcpt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      active <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.kind == KIND_ADVANCE) begin
              idx   <= '0;
              state <= S_SCAN;
            end else if (cmd.kind == KIND_INSTALL && ch_ok) begin
              active[cmd_addr] <= 1'b1;
            end else if (cmd.kind == KIND_REMOVE && ch_ok) begin
              active[cmd_addr] <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (active[idx]) begin
            state <= S_READ;
          end else if (idx == IDX_W'(NUM_CHANNELS - 1)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          state <= (period_rd != '0) ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (more) begin
              idx   <= idx + 1'b1;
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.kind == KIND_ADVANCE) begin
      el <= cmd.elapsed;
    end
    if (state == S_CALC) begin
      count <= '0;
    end else if (state == S_DIV && div_rsp.done) begin
      // saturate the quotient to the count width
      count <= (div_rsp.quot[SUM_W-1:COUNT_W] != '0) ? '1 : div_rsp.quot[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      res_chan  <= CHAN_W'(idx);
      res_count <= count;
      res_last  <= !more;
    end
  end

  assign res.valid         = res_valid;
  assign res.fired_channel = res_chan;
  assign res.fire_count    = res_count;
  assign res.last          = res_last;

`ifndef SYNTH
  a_calc_active: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> active[idx])
    else $error("reading a channel that is not active");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_req.divisor != '0)
    else $error("divider started with a zero period");

  a_emit_holds_active: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_go && more) |=> state == S_SCAN && active != '0)
    else $error("scan resumed with no channel left");
`endif

endmodule

FILE: rtl/core/mcpt_ram.sv
// generic single write port ram with registered read
module mcpt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/mcpt_div.sv
// restoring divider, one quotient bit per cycle
module mcpt_div (
  input  logic              clk,
  input  logic              rst,
  input  mcpt_pkg::div_req_t req,
  output mcpt_pkg::div_rsp_t rsp
);
  import mcpt_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [PERIOD_W-1:0] rem;
  logic [SUM_W-1:0]    quo;
  logic [PERIOD_W-1:0] dvs;
  logic [SUM_W-1:0]    trial;
  logic [SUM_W-1:0]    dvs_ext;
  logic                ge;

  // partial remainder stays below the divisor, so it fits the period width
  assign trial   = {rem, quo[SUM_W-1]};
  assign dvs_ext = {1'b0, dvs};
  assign ge      = trial >= dvs_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? PERIOD_W'(trial - dvs_ext) : trial[PERIOD_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule
